// ===== sv/rbpb_pkg.sv =====
// shared types, codes and arithmetic helpers for the rgba blit pixel blend block
package rbpb_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  localparam logic [7:0] ChanMax = 8'd255;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_a;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       write_pixel;
  } pix_out_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MUL_RED,
    CFG_MUL_GREEN,
    CFG_MUL_BLUE,
    CFG_MUL_ALPHA,
    CFG_BLEND_EN
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] mul_red;
    logic [7:0] mul_green;
    logic [7:0] mul_blue;
    logic [7:0] mul_alpha;
    logic       blend_en;
  } cfg_t;

  typedef enum logic [2:0] {
    MODE_TINT_COPY,
    MODE_SKIP,
    MODE_TINT_BLEND,
    MODE_SRC_COPY,
    MODE_STRAIGHT
  } mode_e;

  typedef struct packed {
    mode_e   mode;
    pix_in_t pix;
  } job_t;

  // exact floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

  function automatic logic [7:0] sat_add(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b);
    return s[8] ? ChanMax : s[7:0];
  endfunction

endpackage

// ===== sv/rbpb_fifo.sv =====
// small register queue, used between front and back and as the result queue
module rbpb_fifo import rbpb_pkg::*; #(
  parameter int  Depth = 4,
  parameter type T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PtrW = $clog2(Depth);

  T               mem_q [Depth];
  logic [PtrW:0]  wr_q, wr_d;
  logic [PtrW:0]  rd_q, rd_d;
  logic           do_push, do_pop;

  assign full_o  = (wr_q[PtrW] != rd_q[PtrW]) && (wr_q[PtrW-1:0] == rd_q[PtrW-1:0]);
  assign empty_o = (wr_q == rd_q);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q[PtrW-1:0]];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (do_push) begin
      wr_d = wr_q + (PtrW+1)'(1);
    end
    if (do_pop) begin
      rd_d = rd_q + (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q[PtrW-1:0]] <= data_i;
    end
  end

endmodule

// ===== sv/rbpb_front.sv =====
// front end: tint and blend registers, per-pixel case classification
module rbpb_front import rbpb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  pix_in_t             pix_i,
  output job_t                job_o,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic tint_white;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MUL_RED:   cfg_d.mul_red   = cfg_data_i;
        CFG_MUL_GREEN: cfg_d.mul_green = cfg_data_i;
        CFG_MUL_BLUE:  cfg_d.mul_blue  = cfg_data_i;
        CFG_MUL_ALPHA: cfg_d.mul_alpha = cfg_data_i;
        CFG_BLEND_EN:  cfg_d.blend_en  = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mul_red: ChanMax, mul_green: ChanMax, mul_blue: ChanMax,
                 mul_alpha: ChanMax, blend_en: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
  assign tint_white = (cfg_q.mul_red == ChanMax) && (cfg_q.mul_green == ChanMax) &&
                      (cfg_q.mul_blue == ChanMax) && (cfg_q.mul_alpha == ChanMax);

  always_comb begin
    job_o.pix = pix_i;
    if (!cfg_q.blend_en) begin
      job_o.mode = MODE_TINT_COPY;
    end else if (pix_i.src_a == 8'd0) begin
      job_o.mode = MODE_SKIP;
    end else if (!tint_white) begin
      job_o.mode = MODE_TINT_BLEND;
    end else if (pix_i.dst_alpha == 8'd0) begin
      job_o.mode = MODE_SRC_COPY;
    end else begin
      job_o.mode = MODE_STRAIGHT;
    end
  end

endmodule

// ===== sv/rbpb_back.sv =====
// back end: six-stage multiply and divide-by-255 pipeline with a common stall
module rbpb_back import rbpb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  job_t     job_i,
  input  logic     job_valid_i,
  output logic     job_pop_o,
  input  cfg_t     cfg_i,
  output pix_out_t res_o,
  output logic     res_push_o,
  input  logic     res_full_i
);

  localparam int NStage = 6;

  logic [NStage-1:0] v_q;
  logic              en;

  logic [7:0] j_src [4];
  logic [7:0] j_dst [3];
  logic [7:0] j_mul [3];

  mode_e       s1_mode_q;
  logic [7:0]  s1_src_q [4];
  logic [7:0]  s1_da_q;
  logic [15:0] s1_pm_q [3];
  logic [15:0] s1_pd_q [3];
  logic [15:0] s1_cp_q [3];
  logic [15:0] s1_tap_q;

  mode_e       s2_mode_q;
  logic [7:0]  s2_src_q [4];
  logic [7:0]  s2_da_q;
  logic [7:0]  s2_pmv_q [3];
  logic [7:0]  s2_pdv_q [3];
  logic [7:0]  s2_cp_q [4];
  logic [7:0]  s2_ta_q;

  mode_e       s3_mode_q;
  logic [7:0]  s3_src_q [4];
  logic [7:0]  s3_da_q;
  logic [15:0] s3_ma_q [3];
  logic [15:0] s3_mb_q [3];
  logic [15:0] s3_ms_q [3];
  logic [7:0]  s3_pdv_q [3];
  logic [7:0]  s3_cp_q [4];
  logic [7:0]  s3_ta_q;

  mode_e       s4_mode_q;
  logic [7:0]  s4_src_q [4];
  logic [7:0]  s4_da_q;
  logic [7:0]  s4_r1_q [3];
  logic [7:0]  s4_st_q [3];
  logic [7:0]  s4_pdv_q [3];
  logic [7:0]  s4_cp_q [4];
  logic [7:0]  s4_ta_q;

  mode_e       s5_mode_q;
  logic [7:0]  s5_src_q [4];
  logic [7:0]  s5_da_q;
  logic [15:0] s5_m2a_q [3];
  logic [15:0] s5_m2b_q [3];
  logic [7:0]  s5_st_q [3];
  logic [7:0]  s5_cp_q [4];
  logic [7:0]  s5_ta_q;

  pix_out_t    s6_res_q, s6_res_d;
  logic [7:0]  r2 [3];

  // the whole pipe holds when the last stage cannot drain
  assign en         = !(v_q[NStage-1] && res_full_i);
  assign job_pop_o  = en && job_valid_i;
  assign res_push_o = v_q[NStage-1] && !res_full_i;
  assign res_o      = s6_res_q;

  always_comb begin
    j_src[0] = job_i.pix.src_red;
    j_src[1] = job_i.pix.src_green;
    j_src[2] = job_i.pix.src_blue;
    j_src[3] = job_i.pix.src_a;
    j_dst[0] = job_i.pix.dst_red;
    j_dst[1] = job_i.pix.dst_green;
    j_dst[2] = job_i.pix.dst_blue;
    j_mul[0] = cfg_i.mul_red;
    j_mul[1] = cfg_i.mul_green;
    j_mul[2] = cfg_i.mul_blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStage-2:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1: premultiply products and tint products
      s1_mode_q <= job_i.mode;
      s1_da_q   <= job_i.pix.dst_alpha;
      s1_tap_q  <= 16'(cfg_i.mul_alpha) * 16'(job_i.pix.src_a);
      for (int c = 0; c < 4; c++) begin
        s1_src_q[c] <= j_src[c];
      end
      for (int c = 0; c < 3; c++) begin
        s1_pm_q[c] <= 16'(j_mul[c]) * 16'(cfg_i.mul_alpha);
        s1_pd_q[c] <= 16'(j_dst[c]) * 16'(job_i.pix.dst_alpha);
        s1_cp_q[c] <= 16'(j_mul[c]) * 16'(j_src[c]);
      end

      // stage 2: divide by 255, tinted copy by shift
      s2_mode_q  <= s1_mode_q;
      s2_da_q    <= s1_da_q;
      s2_ta_q    <= div255(s1_tap_q);
      s2_cp_q[3] <= s1_tap_q[15:8];
      for (int c = 0; c < 4; c++) begin
        s2_src_q[c] <= s1_src_q[c];
      end
      for (int c = 0; c < 3; c++) begin
        s2_pmv_q[c] <= div255(s1_pm_q[c]);
        s2_pdv_q[c] <= div255(s1_pd_q[c]);
        s2_cp_q[c]  <= s1_cp_q[c][15:8];
      end

      // stage 3: first mix products, weighted by source alpha
      s3_mode_q <= s2_mode_q;
      s3_da_q   <= s2_da_q;
      s3_ta_q   <= s2_ta_q;
      for (int c = 0; c < 4; c++) begin
        s3_src_q[c] <= s2_src_q[c];
        s3_cp_q[c]  <= s2_cp_q[c];
      end
      for (int c = 0; c < 3; c++) begin
        s3_ma_q[c]  <= 16'(s2_pmv_q[c]) * 16'(ChanMax - s2_src_q[3]);
        s3_mb_q[c]  <= 16'(s2_src_q[c]) * 16'(s2_src_q[3]);
        s3_ms_q[c]  <= 16'(s2_pdv_q[c]) * 16'(ChanMax - s2_src_q[3]);
        s3_pdv_q[c] <= s2_pdv_q[c];
      end

      // stage 4: source over tint and source over destination
      s4_mode_q <= s3_mode_q;
      s4_da_q   <= s3_da_q;
      s4_ta_q   <= s3_ta_q;
      for (int c = 0; c < 4; c++) begin
        s4_src_q[c] <= s3_src_q[c];
        s4_cp_q[c]  <= s3_cp_q[c];
      end
      for (int c = 0; c < 3; c++) begin
        s4_r1_q[c]  <= div255(s3_ma_q[c]) + div255(s3_mb_q[c]);
        s4_st_q[c]  <= div255(s3_ms_q[c]) + div255(s3_mb_q[c]);
        s4_pdv_q[c] <= s3_pdv_q[c];
      end

      // stage 5: second mix products, weighted by tinted alpha
      s5_mode_q <= s4_mode_q;
      s5_da_q   <= s4_da_q;
      s5_ta_q   <= s4_ta_q;
      for (int c = 0; c < 4; c++) begin
        s5_src_q[c] <= s4_src_q[c];
        s5_cp_q[c]  <= s4_cp_q[c];
      end
      for (int c = 0; c < 3; c++) begin
        s5_m2a_q[c] <= 16'(s4_pdv_q[c]) * 16'(ChanMax - s4_ta_q);
        s5_m2b_q[c] <= 16'(s4_r1_q[c]) * 16'(s4_ta_q);
        s5_st_q[c]  <= s4_st_q[c];
      end

      // stage 6: final select
      s6_res_q <= s6_res_d;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r2[c] = div255(s5_m2a_q[c]) + div255(s5_m2b_q[c]);
    end
  end

  always_comb begin
    s6_res_d.write_pixel = 1'b1;
    case (s5_mode_q)
      MODE_TINT_COPY: begin
        s6_res_d.out_red   = s5_cp_q[0];
        s6_res_d.out_green = s5_cp_q[1];
        s6_res_d.out_blue  = s5_cp_q[2];
        s6_res_d.out_alpha = s5_cp_q[3];
      end
      MODE_SKIP: begin
        s6_res_d.out_red     = 8'd0;
        s6_res_d.out_green   = 8'd0;
        s6_res_d.out_blue    = 8'd0;
        s6_res_d.out_alpha   = 8'd0;
        s6_res_d.write_pixel = 1'b0;
      end
      MODE_TINT_BLEND: begin
        s6_res_d.out_red   = r2[0];
        s6_res_d.out_green = r2[1];
        s6_res_d.out_blue  = r2[2];
        s6_res_d.out_alpha = sat_add(s5_da_q, s5_ta_q);
      end
      MODE_SRC_COPY: begin
        s6_res_d.out_red   = s5_src_q[0];
        s6_res_d.out_green = s5_src_q[1];
        s6_res_d.out_blue  = s5_src_q[2];
        s6_res_d.out_alpha = s5_src_q[3];
      end
      MODE_STRAIGHT: begin
        s6_res_d.out_red   = s5_st_q[0];
        s6_res_d.out_green = s5_st_q[1];
        s6_res_d.out_blue  = s5_st_q[2];
        s6_res_d.out_alpha = sat_add(s5_da_q, s5_src_q[3]);
      end
      default: begin
        s6_res_d.out_red     = 8'd0;
        s6_res_d.out_green   = 8'd0;
        s6_res_d.out_blue    = 8'd0;
        s6_res_d.out_alpha   = 8'd0;
        s6_res_d.write_pixel = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/rgba_blit_pixel_blend_top.sv =====
// top level of the rgba blit pixel blend block
//
// usage:
// - input channel: a source and destination pixel word goes in on in_i and is
//   taken at a clock edge with push_i high and full_o low
// - result channel: the oldest result word sits on out_o while empty_o is low,
//   and is taken at a clock edge with pop_i high
// - config: cfg_we_i with cfg_idx_i / cfg_data_i writes one register at once;
//   write only while no pixel is in flight
// - throughput: one pixel per clock, sustained while the receiver keeps up; no dependence between pixels
// - path: an accepted word is written to the front queue, runs through the back
//   pipeline stages and is written to the result queue before empty_o drops, a
//   depth set by the multiply / divide-by-255 chain of the two nested blends
// - receiver stall: the result queue fills, the back pipeline freezes as a
//   whole, then the front queue fills and full_o rises; no word is dropped
// - reset: both queues empty, tint is white, blending off
module rgba_blit_pixel_blend_top import rbpb_pkg::*; #(
  parameter int MidDepth = 4,
  parameter int OutDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel input
  input  logic                push_i,
  output logic                full_o,
  input  pix_in_t             in_i,
  // result output
  output logic                empty_o,
  input  logic                pop_i,
  output pix_out_t            out_o,
  // register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  job_t     front_job;
  cfg_t     cfg;
  job_t     mid_job;
  logic     mid_empty;
  logic     mid_pop;
  pix_out_t res;
  logic     res_push;
  logic     res_full;

  // classify pixel on the way in, config registers live here too
  rbpb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (in_i),
    .job_o      (front_job),
    .cfg_o      (cfg)
  );

  // decouples the input handshake from the back pipeline stall
  rbpb_fifo #(
    .Depth (MidDepth),
    .T     (job_t)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (front_job),
    .full_o  (full_o),
    .pop_i   (mid_pop),
    .data_o  (mid_job),
    .empty_o (mid_empty)
  );

  // arithmetic for all pixel cases, one pixel per clock unless the result queue is full
  rbpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (mid_job),
    .job_valid_i (!mid_empty),
    .job_pop_o   (mid_pop),
    .cfg_i       (cfg),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result words wait here for the receiver
  rbpb_fifo #(
    .Depth (OutDepth),
    .T     (pix_out_t)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (out_o),
    .empty_o (empty_o)
  );

endmodule

// ===== sv/rbpb_checker.sv =====
// port-level checker for the rgba blit pixel blend block, with its bind
module rbpb_checker import rbpb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push_i,
  input logic                full_o,
  input logic                empty_o,
  input logic                pop_i,
  input pix_out_t            out_o
);

  logic [7:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;

  assign in_acc  = push_i && !full_o;
  assign out_acc = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 8'd1;
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // nothing in flight: no result shown and room at the input
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 8'd0) |-> (empty_o && !full_o))
    else $error("result or full shown with no word in flight");

  // a skipped pixel carries a cleared color
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !out_o.write_pixel) |->
      (out_o.out_red == 8'd0 && out_o.out_green == 8'd0 &&
       out_o.out_blue == 8'd0 && out_o.out_alpha == 8'd0))
    else $error("skipped pixel with nonzero color");

  a_res_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> !empty_o)
    else $error("result withdrawn before pop");

  a_res_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> $stable(out_o))
    else $error("stalled result word changed");

endmodule

bind rgba_blit_pixel_blend_top rbpb_checker u_rbpb_checker (.*);

// ===== test/testbench.sv =====
// self-checking testbench for the rgba blit pixel blend top level
module testbench import rbpb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // idle wait after the last result is popped, to let the pipeline run dry
  localparam int DrainCycles  = 20;
  localparam int RxHoldCycles = 300;
  localparam int CycleLimit   = 200000;
  localparam int PrintMax     = 100;

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                push_i     = 1'b0;
  logic                full_o;
  pix_in_t             in_i       = '0;
  logic                empty_o;
  logic                pop_i      = 1'b0;
  pix_out_t            out_o;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  rgba_blit_pixel_blend_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_i       (in_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // shadow copy of the tint registers, matches the block's reset state
  cfg_t tint_cfg = '{mul_red: ChanMax, mul_green: ChanMax, mul_blue: ChanMax,
                     mul_alpha: ChanMax, blend_en: 1'b0};

  pix_in_t  pix_pending[$];   // words waiting for the driver
  pix_out_t pix_expected[$];  // predicted results, oldest first

  int tx_idle_pct  = 0;  // chance per cycle that the driver holds push low
  int rx_stall_pct = 0;  // chance per cycle that the monitor holds pop low
  int hold_req     = 0;  // bumped by the sequencer to ask for a long receiver hold
  int hold_seen    = 0;
  int hold_left    = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // ---------------------------------------------------------------------------
  // blend arithmetic; divisions by 255 are floor divisions, the tinted copy uses a shift
  // ---------------------------------------------------------------------------

  function automatic int unsigned premul255(int unsigned c, int unsigned a);
    return (c * a) / 255;
  endfunction

  // under faded by (255 - k) plus over weighted by k
  function automatic int unsigned mix_over(int unsigned under, int unsigned over,
                                           int unsigned k);
    return (under * (255 - k)) / 255 + (over * k) / 255;
  endfunction

  // expected result word for one source / destination pair under tint_cfg
  function automatic pix_out_t blend_pixel(pix_in_t p);
    pix_out_t    o;
    int unsigned r, g, b, a, ta;
    bit          tinted;
    o = '0;
    o.write_pixel = 1'b1;
    tinted = (tint_cfg.mul_red != ChanMax) || (tint_cfg.mul_green != ChanMax) ||
             (tint_cfg.mul_blue != ChanMax) || (tint_cfg.mul_alpha != ChanMax);
    if (!tint_cfg.blend_en) begin
      // tinted copy, destination ignored
      r = (int'(tint_cfg.mul_red) * int'(p.src_red)) >> 8;
      g = (int'(tint_cfg.mul_green) * int'(p.src_green)) >> 8;
      b = (int'(tint_cfg.mul_blue) * int'(p.src_blue)) >> 8;
      a = (int'(tint_cfg.mul_alpha) * int'(p.src_a)) >> 8;
    end else if (p.src_a == 8'd0) begin
      // transparent source: nothing written, fields zero
      r = 0;
      g = 0;
      b = 0;
      a = 0;
      o.write_pixel = 1'b0;
    end else if (tinted) begin
      // source over premultiplied tint, then over premultiplied destination
      ta = premul255(tint_cfg.mul_alpha, p.src_a);
      r = mix_over(premul255(tint_cfg.mul_red, tint_cfg.mul_alpha), p.src_red, p.src_a);
      g = mix_over(premul255(tint_cfg.mul_green, tint_cfg.mul_alpha), p.src_green,
                   p.src_a);
      b = mix_over(premul255(tint_cfg.mul_blue, tint_cfg.mul_alpha), p.src_blue,
                   p.src_a);
      r = mix_over(premul255(p.dst_red, p.dst_alpha), r, ta);
      g = mix_over(premul255(p.dst_green, p.dst_alpha), g, ta);
      b = mix_over(premul255(p.dst_blue, p.dst_alpha), b, ta);
      a = p.dst_alpha + ta;
    end else if (p.dst_alpha == 8'd0) begin
      // white tint onto empty destination: plain copy
      r = p.src_red;
      g = p.src_green;
      b = p.src_blue;
      a = p.src_a;
    end else begin
      // straight source over premultiplied destination
      r = mix_over(premul255(p.dst_red, p.dst_alpha), p.src_red, p.src_a);
      g = mix_over(premul255(p.dst_green, p.dst_alpha), p.src_green, p.src_a);
      b = mix_over(premul255(p.dst_blue, p.dst_alpha), p.src_blue, p.src_a);
      a = p.dst_alpha + p.src_a;
    end
    if (a > 255) begin
      a = 255;
    end
    o.out_red   = 8'(r);
    o.out_green = 8'(g);
    o.out_blue  = 8'(b);
    o.out_alpha = 8'(a);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // channel value biased toward the edges of the range
  function automatic logic [7:0] pick_chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_in_t rand_pix();
    pix_in_t p;
    p.src_red   = pick_chan();
    p.src_green = pick_chan();
    p.src_blue  = pick_chan();
    p.src_a     = pick_chan();
    p.dst_red   = pick_chan();
    p.dst_green = pick_chan();
    p.dst_blue  = pick_chan();
    p.dst_alpha = pick_chan();
    return p;
  endfunction

  task automatic add_pix(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb, logic [7:0] sa,
                         logic [7:0] dr, logic [7:0] dg, logic [7:0] db, logic [7:0] da);
    pix_pending.push_back('{src_red: sr, src_green: sg, src_blue: sb, src_a: sa,
                            dst_red: dr, dst_green: dg, dst_blue: db, dst_alpha: da});
  endtask

  // one register write; only called while nothing is in flight
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MUL_RED:   tint_cfg.mul_red   = data;
      CFG_MUL_GREEN: tint_cfg.mul_green = data;
      CFG_MUL_BLUE:  tint_cfg.mul_blue  = data;
      CFG_MUL_ALPHA: tint_cfg.mul_alpha = data;
      CFG_BLEND_EN:  tint_cfg.blend_en  = data[0];
      default: ;  // unused index, block ignores it
    endcase
  endtask

  // the blend enable is written with random upper bits, which must be ignored
  task automatic set_tint(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                          logic en);
    write_reg(CFG_MUL_RED, r);
    write_reg(CFG_MUL_GREEN, g);
    write_reg(CFG_MUL_BLUE, b);
    write_reg(CFG_MUL_ALPHA, a);
    write_reg(CFG_BLEND_EN, {7'($urandom), en});
  endtask

  // wait for every queued word to go in and every result to come out,
  // then let the pipeline run dry
  task automatic settle();
    while (pix_pending.size() != 0 || push_i || pix_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random(int n, int tx_pct, int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n; i++) begin
      pix_pending.push_back(rand_pix());
    end
    settle();
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count < PrintMax) begin
      $display("mismatch @%0d: %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers pending words, keeps a word steady while full_o is high
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // word taken at this edge: predict it under the current tint
      if (push_i && !full_o) begin
        pix_expected.push_back(blend_pixel(in_i));
      end
      // a stalled word stays on the port untouched
      if (!(push_i && full_o)) begin
        if (pix_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          push_i <= 1'b1;
          in_i   <= pix_pending.pop_front();
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each popped word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pix_out_t want;
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (pix_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_o));
        end else begin
          want = pix_expected.pop_front();
          if (out_o.out_red !== want.out_red)
            report_mismatch($sformatf("out_red got %0d want %0d",
                                      out_o.out_red, want.out_red));
          if (out_o.out_green !== want.out_green)
            report_mismatch($sformatf("out_green got %0d want %0d",
                                      out_o.out_green, want.out_green));
          if (out_o.out_blue !== want.out_blue)
            report_mismatch($sformatf("out_blue got %0d want %0d",
                                      out_o.out_blue, want.out_blue));
          if (out_o.out_alpha !== want.out_alpha)
            report_mismatch($sformatf("out_alpha got %0d want %0d",
                                      out_o.out_alpha, want.out_alpha));
          if (out_o.write_pixel !== want.write_pixel)
            report_mismatch($sformatf("write_pixel got %0d want %0d",
                                      out_o.write_pixel, want.write_pixel));
        end
      end
      // long hold asked by the sequencer, counted down here
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = RxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL rgba_blit_pixel_blend_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: directed cases, then random phases with varied tint and idling
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset tint is white with blending off: near-identity copy
    add_pix(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    add_pix(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    add_pix(8'd128, 8'd1, 8'd254, 8'd0, 8'd17, 8'd99, 8'd3, 8'd200);
    settle();

    // tinted copy with mixed tint channels, destination ignored
    set_tint(8'd0, 8'd255, 8'd128, 8'd1, 1'b0);
    add_pix(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    add_pix(8'd200, 8'd100, 8'd7, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    settle();

    // white tint, blending on: skip, plain copy, straight blend, saturation
    set_tint(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    add_pix(8'd90, 8'd80, 8'd70, 8'd0, 8'd10, 8'd20, 8'd30, 8'd40);
    add_pix(8'd90, 8'd80, 8'd70, 8'd60, 8'd10, 8'd20, 8'd30, 8'd0);
    add_pix(8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255);
    add_pix(8'd1, 8'd2, 8'd3, 8'd1, 8'd250, 8'd251, 8'd252, 8'd1);
    add_pix(8'd40, 8'd160, 8'd240, 8'd128, 8'd200, 8'd100, 8'd50, 8'd200);
    settle();

    // writes to unused register indexes must change nothing
    for (int k = int'(CFG_BLEND_EN) + 1; k < (1 << CfgIdxW); k++) begin
      write_reg(CfgIdxW'(k), 8'($urandom));
    end
    add_pix(8'd33, 8'd66, 8'd99, 8'd132, 8'd165, 8'd198, 8'd231, 8'd64);
    settle();

    // non-white tint: two nested blends
    set_tint(8'd200, 8'd100, 8'd50, 8'd128, 1'b1);
    add_pix(8'd90, 8'd80, 8'd70, 8'd0, 8'd10, 8'd20, 8'd30, 8'd40);
    add_pix(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    add_pix(8'd10, 8'd20, 8'd30, 8'd255, 8'd99, 8'd99, 8'd99, 8'd0);
    add_pix(8'd250, 8'd5, 8'd128, 8'd1, 8'd60, 8'd70, 8'd80, 8'd128);
    settle();

    // black transparent tint, then tints off white in one channel only
    set_tint(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    add_pix(8'd255, 8'd255, 8'd255, 8'd255, 8'd100, 8'd100, 8'd100, 8'd100);
    add_pix(8'd12, 8'd34, 8'd56, 8'd78, 8'd255, 8'd0, 8'd255, 8'd255);
    settle();
    set_tint(8'd255, 8'd255, 8'd255, 8'd254, 1'b1);
    add_pix(8'd200, 8'd150, 8'd100, 8'd255, 8'd50, 8'd60, 8'd70, 8'd0);
    add_pix(8'd200, 8'd150, 8'd100, 8'd128, 8'd50, 8'd60, 8'd70, 8'd255);
    settle();
    set_tint(8'd255, 8'd255, 8'd254, 8'd255, 1'b1);
    add_pix(8'd1, 8'd254, 8'd77, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0);
    settle();

    // random phases; idling cycles through none / sender / receiver / both
    set_tint(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    run_random(170, 0, 0);

    // sender pauses halfway until every result is back
    set_tint(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b1);
    run_random(85, 67, 0);
    run_random(85, 67, 0);

    set_tint(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b0);
    run_random(170, 0, 67);

    set_tint(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    run_random(170, 31, 31);

    // receiver holds off while the sender streams, so full_o has to rise
    set_tint(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    hold_req++;
    run_random(170, 0, 0);

    set_tint(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    run_random(170, 67, 0);

    set_tint(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    run_random(170, 0, 67);

    set_tint(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b1);
    run_random(170, 31, 31);

    if (mismatch_count == 0) begin
      $display("PASS rgba_blit_pixel_blend_top");
    end else begin
      $display("FAIL rgba_blit_pixel_blend_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rbpb_pkg.sv
sv/rbpb_fifo.sv
sv/rbpb_front.sv
sv/rbpb_back.sv
sv/rgba_blit_pixel_blend_top.sv
sv/rbpb_checker.sv
test/testbench.sv
